### rtl/core/apd_pkg.sv
// Shared types and constants for the all-pairs hop distance block.
`default_nettype none

package apd_pkg;

  localparam int IDX_W  = 6;
  localparam int DIST_W = 7;
  localparam int ADDR_W = 2 * IDX_W;

  // node count and unreachable code
  localparam logic [DIST_W-1:0] MaxNodes = 7'd64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] row_node;
    logic [IDX_W-1:0] col_node;
    logic             connected;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_IK_RD,
    ST_IK_CHK,
    ST_RD,
    ST_WR,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

### rtl/core/apd_engine.sv
// Distance matrix memory and the sequencer that loads, reads and relaxes it.
`default_nettype none

module apd_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire apd_pkg::req_t              req,
  input  wire logic [apd_pkg::DIST_W-1:0] node_count,
  input  wire logic                       rsp_free,
  output apd_pkg::ctl_t                   ctl,
  output apd_pkg::rsp_t                   res
);

  apd_pkg::state_t state, state_next;

  logic [apd_pkg::DIST_W-1:0] mem [2**apd_pkg::ADDR_W];
  logic [apd_pkg::DIST_W-1:0] rd_a, rd_b;
  logic [apd_pkg::ADDR_W-1:0] ra, rb, waddr;
  logic [apd_pkg::DIST_W-1:0] wdata;
  logic                       we;

  logic [apd_pkg::IDX_W-1:0]  k, k_next, i, i_next, j, j_next;
  logic [apd_pkg::DIST_W-1:0] ik, ik_next;
  apd_pkg::rsp_t              res_next;

  logic [apd_pkg::DIST_W-1:0] n_eff;
  logic [apd_pkg::IDX_W-1:0]  last;
  logic [apd_pkg::DIST_W:0]   sum;
  logic                       next_row;

  assign n_eff = (node_count > apd_pkg::MaxNodes) ? apd_pkg::MaxNodes : node_count;
  assign last  = apd_pkg::IDX_W'(n_eff - 7'd1);
  assign sum   = {1'b0, ik} + {1'b0, rd_a};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    k   <= k_next;
    i   <= i_next;
    j   <= j_next;
    ik  <= ik_next;
    res <= res_next;
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    i_next     = i;
    j_next     = j;
    ik_next    = ik;
    res_next   = res;
    we         = 1'b0;
    waddr      = {req.row_node, req.col_node};
    wdata      = '0;
    ra         = '0;
    rb         = '0;
    next_row   = 1'b0;
    ctl.idle   = 1'b0;
    ctl.done   = 1'b0;

    unique case (state)
      apd_pkg::ST_IDLE: begin
        ctl.idle = 1'b1;
        ra       = {req.row_node, req.col_node};
        if (start) begin
          res_next = '0;
          unique case (req.op)
            apd_pkg::OP_WRITE: begin
              we = 1'b1;
              if (req.row_node == req.col_node) begin
                wdata = '0;
              end else if (req.connected) begin
                wdata = 7'd1;
              end else begin
                wdata = apd_pkg::MaxNodes;
              end
              state_next = apd_pkg::ST_RESP;
            end
            apd_pkg::OP_READ: begin
              state_next = apd_pkg::ST_RD_WAIT;
            end
            apd_pkg::OP_CLOSE: begin
              k_next     = '0;
              i_next     = '0;
              state_next = (n_eff == '0) ? apd_pkg::ST_RESP : apd_pkg::ST_IK_RD;
            end
            default: begin
              state_next = apd_pkg::ST_RESP;
            end
          endcase
        end
      end
      apd_pkg::ST_RD_WAIT: begin
        res_next.distance  = rd_a;
        res_next.reachable = rd_a < apd_pkg::MaxNodes;
        state_next         = apd_pkg::ST_RESP;
      end
      apd_pkg::ST_IK_RD: begin
        ra         = {i, k};
        state_next = apd_pkg::ST_IK_CHK;
      end
      apd_pkg::ST_IK_CHK: begin
        // rows with no usable path to the pivot are skipped whole
        if (rd_a == '0 || rd_a >= apd_pkg::MaxNodes) begin
          next_row = 1'b1;
        end else begin
          ik_next    = rd_a;
          j_next     = '0;
          state_next = apd_pkg::ST_RD;
        end
      end
      apd_pkg::ST_RD: begin
        ra         = {k, j};
        rb         = {i, j};
        state_next = apd_pkg::ST_WR;
      end
      apd_pkg::ST_WR: begin
        waddr = {i, j};
        wdata = sum[apd_pkg::DIST_W-1:0];
        if (rd_a != '0 && rd_a < apd_pkg::MaxNodes && sum < {1'b0, rd_b}) begin
          we = 1'b1;
        end
        if (j == last) begin
          next_row = 1'b1;
        end else begin
          j_next     = j + 6'd1;
          state_next = apd_pkg::ST_RD;
        end
      end
      apd_pkg::ST_RESP: begin
        if (rsp_free) begin
          ctl.done   = 1'b1;
          state_next = apd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = apd_pkg::ST_IDLE;
      end
    endcase

    if (next_row) begin
      if (i == last) begin
        i_next = '0;
        if (k == last) begin
          state_next = apd_pkg::ST_RESP;
        end else begin
          k_next     = k + 6'd1;
          state_next = apd_pkg::ST_IK_RD;
        end
      end else begin
        i_next     = i + 6'd1;
        state_next = apd_pkg::ST_IK_RD;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/all_pairs_hop_distance.sv
// Top level: all-pairs hop distance over a 64-node adjacency matrix.
//
// Request channel (req_valid/req_ready, payload req) carries one op per beat:
//   write adjacency entry, run the all-pairs closure, or read one distance.
// Response channel (rsp_valid/rsp_ready, payload rsp) returns one beat per
//   request, in order; distance 64 means unreachable.
// cfg_we/cfg_data set node_count (values above 64 act as 64, zero makes
//   the closure a no-op); write it only while the block is idle.
// A write goes from ST_IDLE to ST_RESP, a read through ST_RD_WAIT to ST_RESP;
//   ST_RESP waits for the output register to free before filling it.
//   The closure is sequenced through one dual-read memory and one adder:
//   per pivot k and row i, d(i,k) is fetched (ST_IK_RD, ST_IK_CHK), and when
//   that entry is usable each column j is read (ST_RD) and relaxed (ST_WR).
// One request is in work at a time; req_ready is high only when the
//   sequencer is idle. A finished response sits in the output register
//   while the next request is taken; if rsp_ready stays low, the following
//   request's result waits inside until the register frees.
// Reset clears control state and sets node_count to 64. Matrix contents are
//   undefined until written, and no clearing pass is run.
`default_nettype none

module all_pairs_hop_distance (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire apd_pkg::req_t              req,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output apd_pkg::rsp_t                   rsp,
  input  wire logic                       cfg_we,
  input  wire logic [apd_pkg::DIST_W-1:0] cfg_data
);

  logic [apd_pkg::DIST_W-1:0] node_count;
  apd_pkg::ctl_t              ctl;
  apd_pkg::rsp_t              res;
  logic                       rsp_free;

  assign req_ready = ctl.idle;
  assign rsp_free  = !rsp_valid || rsp_ready;

  apd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (req_valid && req_ready),
    .req        (req),
    .node_count (node_count),
    .rsp_free   (rsp_free),
    .ctl        (ctl),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= apd_pkg::MaxNodes;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (ctl.done) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/apd_checker.sv
// Port-level checks for all_pairs_hop_distance, bound to the top level.
`default_nettype none

module apd_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire apd_pkg::rsp_t rsp,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_reach_dist: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reachable |-> rsp.distance < apd_pkg::MaxNodes)
    else $error("reachable with unreachable distance");

  // unreachable answers are either the unreachable code or a non-read zero
  a_unreach_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.reachable |->
      rsp.distance == '0 || rsp.distance == apd_pkg::MaxNodes)
    else $error("bad distance on unreachable beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");

endmodule

bind all_pairs_hop_distance apd_checker u_apd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the all-pairs hop distance block.
`default_nettype none

module tb_top;

  localparam logic [1:0] OP_SPARE = 2'd3;
  // watchdog limit; the longest closure driven here has 7 nodes
  localparam int StallLimit = 20_000;

  typedef enum int {
    GRAPH_CHAIN,
    GRAPH_SPARSE,
    GRAPH_DENSE,
    GRAPH_BLOCK
  } graph_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  apd_pkg::req_t req_beat = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  apd_pkg::rsp_t rsp_beat;
  logic cfg_we = 1'b0;
  logic [apd_pkg::DIST_W-1:0] cfg_data = '0;

  all_pairs_hop_distance DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_beat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_beat),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [apd_pkg::DIST_W-1:0] hop_dist [0:4095];
  logic [apd_pkg::DIST_W-1:0] node_limit = apd_pkg::MaxNodes;

  // entries written so far, as seen by the stimulus generator
  bit loaded [0:4095];

  apd_pkg::req_t pending_beats [$];
  apd_pkg::rsp_t expected_hops [$];
  int beats_queued = 0;
  int beats_checked = 0;
  int fail_count = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 83;
  int send_quiet = 0;
  int recv_quiet = 0;
  int stall_cycles = 0;
  apd_pkg::rsp_t want;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic apd_pkg::rsp_t predict_hop(input apd_pkg::req_t beat);
    apd_pkg::rsp_t res;
    int n, k, i, j, ik, kj;
    res = '0;
    case (beat.op)
      apd_pkg::OP_WRITE: begin
        if (beat.row_node == beat.col_node) begin
          hop_dist[{beat.row_node, beat.col_node}] = '0;
        end else if (beat.connected) begin
          hop_dist[{beat.row_node, beat.col_node}] = apd_pkg::DIST_W'(1);
        end else begin
          hop_dist[{beat.row_node, beat.col_node}] = apd_pkg::MaxNodes;
        end
      end
      apd_pkg::OP_CLOSE: begin
        n = (node_limit > apd_pkg::MaxNodes) ? int'(apd_pkg::MaxNodes) : int'(node_limit);
        for (k = 0; k < n; k++) begin
          for (i = 0; i < n; i++) begin
            ik = int'(hop_dist[i * 64 + k]);
            if (ik == 0 || ik >= int'(apd_pkg::MaxNodes)) continue;
            for (j = 0; j < n; j++) begin
              kj = int'(hop_dist[k * 64 + j]);
              if (kj == 0 || kj >= int'(apd_pkg::MaxNodes)) continue;
              if (ik + kj < int'(hop_dist[i * 64 + j])) begin
                hop_dist[i * 64 + j] = apd_pkg::DIST_W'(ik + kj);
              end
            end
          end
        end
      end
      apd_pkg::OP_READ: begin
        res.distance = hop_dist[{beat.row_node, beat.col_node}];
        res.reachable = (res.distance < apd_pkg::MaxNodes);
      end
      default: ;
    endcase
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_hops.insert(expected_hops.size(), predict_hop(req_beat));
      end
      if (send_quiet > 0) begin
        send_quiet--;
      end else if ($urandom_range(99) < 2) begin
        send_quiet = $urandom_range(60, 20);
      end
      if (!req_valid || req_ready) begin
        if (pending_beats.size() != 0 &&
            (send_quiet > 0 || $urandom_range(99) >= send_idle_pct)) begin
          req_beat <= pending_beats.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_hops.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected beat: distance %0d reachable %0d",
                     rsp_beat.distance, rsp_beat.reachable);
          end
        end else begin
          want = expected_hops.pop_front();
          beats_checked++;
          if (rsp_beat.distance !== want.distance || rsp_beat.reachable !== want.reachable) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at beat %0d: expected distance %0d reachable %0d, got %0d %0d",
                       beats_checked, want.distance, want.reachable,
                       rsp_beat.distance, rsp_beat.reachable);
            end
          end
        end
      end
      if (recv_quiet > 0) begin
        recv_quiet--;
      end else if ($urandom_range(99) < 2) begin
        recv_quiet = $urandom_range(60, 20);
      end
      rsp_ready <= (recv_quiet > 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_beat(input logic [1:0] op, input int row, input int col, input bit link);
    apd_pkg::req_t beat;
    beat.op = op;
    beat.row_node = row[apd_pkg::IDX_W-1:0];
    beat.col_node = col[apd_pkg::IDX_W-1:0];
    beat.connected = link;
    if (op == apd_pkg::OP_WRITE) loaded[{beat.row_node, beat.col_node}] = 1'b1;
    pending_beats.insert(pending_beats.size(), beat);
    beats_queued++;
  endtask

  // read a random written entry, rows and columns below lim, if 32 tries find one
  task automatic queue_read_loaded(input int lim);
    int tries, r, c;
    bit found;
    found = 1'b0;
    for (tries = 0; tries < 32 && !found; tries++) begin
      r = $urandom_range(lim - 1);
      c = $urandom_range(lim - 1);
      found = loaded[r * 64 + c];
    end
    if (found) queue_beat(apd_pkg::OP_READ, r, c, 1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    while (beats_checked != beats_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_nodes(input int value);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value[apd_pkg::DIST_W-1:0];
    node_limit = value[apd_pkg::DIST_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  function automatic bit link_for(input graph_style_t style, input int r, input int c);
    case (style)
      GRAPH_CHAIN:  return (c == r + 1) || ($urandom_range(99) < 5);
      GRAPH_SPARSE: return $urandom_range(99) < 15;
      GRAPH_DENSE:  return $urandom_range(99) < 70;
      default:      return (r / 4 == c / 4) && ($urandom_range(1) == 1);
    endcase
  endfunction

  // load the whole n x n matrix in random order with noise, close, then read back
  task automatic load_and_close(input int nodes_cfg, input graph_style_t style);
    int n, s, pick, tmp, r, c, roll;
    int order [$];
    set_nodes(nodes_cfg);
    n = (nodes_cfg > 64) ? 64 : nodes_cfg;
    for (s = 0; s < n * n; s++) order.insert(order.size(), s);
    for (s = n * n - 1; s > 0; s--) begin
      pick = $urandom_range(s);
      tmp = order[s];
      order[s] = order[pick];
      order[pick] = tmp;
    end
    foreach (order[pos]) begin
      r = order[pos] / n;
      c = order[pos] % n;
      queue_beat(apd_pkg::OP_WRITE, r, c, link_for(style, r, c));
      roll = $urandom_range(99);
      if (roll < 12) begin
        queue_read_loaded(64);
      end else if (roll < 16) begin
        queue_beat(OP_SPARE, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      end else if (roll < 20) begin
        queue_beat(apd_pkg::OP_WRITE, $urandom_range(63), $urandom_range(63),
                   1'($urandom_range(1)));
      end
    end
    queue_beat(apd_pkg::OP_CLOSE, $urandom_range(63), $urandom_range(63),
               1'($urandom_range(1)));
    repeat (2 * n + 6) queue_read_loaded(($urandom_range(99) < 80) ? n : 64);
    // small graphs: patch a few links and close again
    if (n <= 16) begin
      repeat (3) queue_beat(apd_pkg::OP_WRITE, $urandom_range(n - 1), $urandom_range(n - 1),
                            1'($urandom_range(1)));
      queue_beat(apd_pkg::OP_CLOSE, $urandom_range(63), $urandom_range(63),
                 1'($urandom_range(1)));
      repeat (n + 4) queue_read_loaded(n);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: two-node graph, diagonal forcing, far-corner indices, spare op
    set_nodes(2);
    queue_beat(apd_pkg::OP_WRITE, 0, 0, 1'b1);
    queue_beat(apd_pkg::OP_WRITE, 0, 1, 1'b1);
    queue_beat(apd_pkg::OP_WRITE, 1, 0, 1'b0);
    queue_beat(apd_pkg::OP_WRITE, 1, 1, 1'b0);
    queue_beat(apd_pkg::OP_READ, 0, 0, 1'b0);
    queue_beat(apd_pkg::OP_READ, 0, 1, 1'b1);
    queue_beat(apd_pkg::OP_READ, 1, 0, 1'b0);
    queue_beat(apd_pkg::OP_READ, 1, 1, 1'b1);
    queue_beat(apd_pkg::OP_WRITE, 63, 63, 1'b1);
    queue_beat(apd_pkg::OP_WRITE, 63, 0, 1'b1);
    queue_beat(apd_pkg::OP_WRITE, 0, 63, 1'b0);
    queue_beat(apd_pkg::OP_READ, 63, 63, 1'b1);
    queue_beat(apd_pkg::OP_READ, 63, 0, 1'b0);
    queue_beat(apd_pkg::OP_READ, 0, 63, 1'b1);
    queue_beat(OP_SPARE, 63, 63, 1'b1);
    queue_beat(apd_pkg::OP_CLOSE, 0, 0, 1'b0);
    queue_beat(apd_pkg::OP_READ, 1, 0, 1'b0);
    queue_beat(apd_pkg::OP_READ, 0, 1, 1'b0);
    queue_beat(apd_pkg::OP_WRITE, 1, 0, 1'b1);
    queue_beat(apd_pkg::OP_CLOSE, 63, 63, 1'b1);
    queue_beat(apd_pkg::OP_READ, 1, 0, 1'b0);
    queue_beat(apd_pkg::OP_READ, 0, 0, 1'b0);

    load_and_close(1, GRAPH_DENSE);
    load_and_close(4, GRAPH_CHAIN);
    load_and_close(6, GRAPH_SPARSE);

    wait_idle();
    send_idle_pct = 83;
    recv_idle_pct = 19;
    load_and_close(5, GRAPH_DENSE);
    load_and_close(7, GRAPH_SPARSE);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_and_close(6, GRAPH_BLOCK);

    // zero nodes: closure does nothing
    set_nodes(0);
    queue_beat(apd_pkg::OP_WRITE, $urandom_range(63), $urandom_range(63),
               1'($urandom_range(1)));
    queue_beat(apd_pkg::OP_CLOSE, $urandom_range(63), $urandom_range(63),
               1'($urandom_range(1)));
    repeat (10) queue_read_loaded(64);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_hops.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/apd_pkg.sv
rtl/core/apd_engine.sv
rtl/core/all_pairs_hop_distance.sv
rtl/core/apd_checker.sv
tb/tb_top.sv
